[hw/rtl/aodv_rt_pkg.sv]
package aodv_rt_pkg;

    localparam int TableEntries = 64;
    localparam int IdxW = $clog2(TableEntries);

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_UPDATE = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_UNUSABLE = 2'd1,
        ST_STALE    = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_DECIDE,
        S_RDSLOT,
        S_FINISH
    } t_state;

    localparam logic CFG_ACTIVE = 1'b0;
    localparam logic CFG_DELETE = 1'b1;

    typedef struct packed {
        logic [31:0] hop;
        logic [7:0]  metric;
        logic [31:0] seq;
        logic [31:0] lifetime;
    } t_entry;

endpackage

[hw/rtl/aodv_route_table_unit.sv]
// Channel   | Signals                                       | Direction
// request   | i_start, o_busy, i_req_type .. i_next_hop_usable | in
// result    | o_done strobe, o_status .. o_route_lifetime   | out, one cycle
// config    | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | in
// A request keeps o_busy high through one sweep of the entry memory, which at
// one entry a cycle sets the pace, then a decision, a read of the matched slot
// and a final write-back. The result strobe follows in the next cycle, so a new
// request can be taken while the strobe is high. A REQ_NONE request gives its
// result in the cycle after it is taken.
// Reset clears control state, slot-used and valid bits.
// The result strobe lasts one cycle; the receiver cannot stall it.
module aodv_route_table_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_now,
    input  logic [31:0] i_dest_addr,
    input  logic [31:0] i_next_hop_addr,
    input  logic [7:0]  i_hop_metric,
    input  logic [31:0] i_seq_number,
    input  logic        i_next_hop_usable,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic        o_entry_valid,
    output logic [31:0] o_route_next_hop,
    output logic [7:0]  o_route_metric,
    output logic [31:0] o_route_seq,
    output logic [31:0] o_route_lifetime,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import aodv_rt_pkg::*;

    t_state r_state, n_state;
    logic [31:0] r_active, r_delper;
    logic [TableEntries-1:0] r_used, r_valid;
    logic [31:0] r_dest [TableEntries];
    logic [31:0] r_dest_rd;
    t_entry r_mem [TableEntries];
    t_entry r_rd;
    logic [IdxW:0] r_cnt;
    logic [IdxW-1:0] r_rd_idx;
    logic r_rd_vld;
    // latched request
    logic [1:0] r_type;
    logic [31:0] r_now, r_da, r_nh, r_seq;
    logic [7:0] r_met;
    logic r_use;
    // search results
    logic r_found, r_free_ok;
    logic [IdxW-1:0] r_slot, r_free;
    // result registers
    logic r_done, r_fnd_o, r_ev_o;
    logic [1:0] r_st_o;
    t_entry r_ent_o;

    logic wr_en;
    logic [IdxW-1:0] wr_idx;
    t_entry wr_data;
    logic rd_en;
    logic [IdxW-1:0] rd_idx;
    logic expire;
    logic [31:0] d_seq;
    logic newer, accept_upd;

    assign o_busy = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 32'd3000;
            r_delper <= 32'd15000;
        end else if (i_cfg_valid && i_cfg_index[1] == 1'b0) begin
            if (i_cfg_index[0] == CFG_ACTIVE) r_active <= i_cfg_data;
            else r_delper <= i_cfg_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start && i_req_type != REQ_NONE) n_state = S_SWEEP;
            S_SWEEP:  if (r_cnt == (IdxW+1)'(TableEntries)) n_state = S_DECIDE;
            S_DECIDE: n_state = S_RDSLOT;
            S_RDSLOT: n_state = S_FINISH;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    // sweep: issue read at r_cnt, check previous read data
    assign expire = r_rd_vld && r_used[r_rd_idx] && r_valid[r_rd_idx]
                    && (r_rd.lifetime - r_now) >> 31 != 32'd0;
    assign d_seq = r_rd.seq - r_seq;
    assign newer = (d_seq != 32'd0) && !d_seq[31];
    assign accept_upd = r_use && !(r_found && newer) &&
        !(r_found && r_valid[r_slot] && r_seq == r_rd.seq && r_met >= r_rd.metric);

    // memory port control
    always_comb begin
        rd_en = 1'b0;
        rd_idx = r_cnt[IdxW-1:0];
        wr_en = 1'b0;
        wr_idx = r_rd_idx;
        wr_data = r_rd;
        if (r_state == S_SWEEP && r_cnt < (IdxW+1)'(TableEntries)) rd_en = 1'b1;
        if (r_state == S_DECIDE) begin
            rd_en = 1'b1;
            rd_idx = r_slot;
        end
        if (expire && r_state == S_SWEEP) begin
            wr_en = 1'b1;
            wr_data.lifetime = r_now + r_delper;
            wr_data.seq = r_rd.seq + 32'd1;
        end
        if (r_state == S_FINISH && r_type == REQ_UPDATE && accept_upd &&
            (r_found || r_free_ok)) begin
            wr_en = 1'b1;
            wr_idx = r_found ? r_slot : r_free;
            wr_data.hop = r_nh;
            wr_data.metric = r_met;
            wr_data.seq = r_seq;
            wr_data.lifetime = r_now + r_active;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_idx] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_valid <= '0;
            r_cnt <= '0;
            r_rd_vld <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_rd_vld <= rd_en && r_state == S_SWEEP;
            r_rd_idx <= rd_idx;
            if (r_state == S_IDLE && i_start) begin
                r_cnt <= '0;
                r_type <= i_req_type;
                r_now <= i_now;
                r_da <= i_dest_addr;
                r_nh <= i_next_hop_addr;
                r_seq <= i_seq_number;
                r_met <= i_hop_metric;
                r_use <= i_next_hop_usable;
                r_found <= 1'b0;
                r_free_ok <= 1'b0;
                r_slot <= '0;
                r_free <= '0;
                if (i_req_type == REQ_NONE) begin
                    r_done <= 1'b1;
                    r_st_o <= ST_DONE;
                    r_fnd_o <= 1'b0;
                    r_ev_o <= 1'b0;
                    r_ent_o <= '0;
                end
            end
            if (r_state == S_SWEEP) begin
                // match the key against the entry read in the previous cycle
                if (r_rd_vld && !r_found && r_used[r_rd_idx] && r_dest_rd == r_da) begin
                    r_found <= 1'b1;
                    r_slot <= r_rd_idx;
                end
                // pick the lowest free slot during the sweep
                if (r_cnt < (IdxW+1)'(TableEntries)) begin
                    if (!r_free_ok && !r_used[r_cnt[IdxW-1:0]]) begin
                        r_free_ok <= 1'b1;
                        r_free <= r_cnt[IdxW-1:0];
                    end
                end
                r_cnt <= r_cnt + 1'b1;
                if (expire) r_valid[r_rd_idx] <= 1'b0;
            end
            if (r_state == S_FINISH) begin
                r_done <= 1'b1;
                r_fnd_o <= r_found;
                r_st_o <= ST_DONE;
                r_ev_o <= 1'b0;
                r_ent_o <= '0;
                case (r_type)
                    REQ_LOOKUP: if (r_found) begin
                        r_ev_o <= r_valid[r_slot];
                        r_ent_o <= r_rd;
                    end
                    REQ_DELETE: if (r_found) begin
                        r_used[r_slot] <= 1'b0;
                        r_valid[r_slot] <= 1'b0;
                    end
                    REQ_UPDATE: begin
                        if (!r_use) begin
                            r_st_o <= ST_UNUSABLE;
                            if (r_found) begin
                                r_ev_o <= r_valid[r_slot];
                                r_ent_o <= r_rd;
                            end
                        end else if (!accept_upd) begin
                            r_st_o <= ST_STALE;
                            r_ev_o <= r_valid[r_slot];
                            r_ent_o <= r_rd;
                        end else if (!r_found && !r_free_ok) begin
                            r_st_o <= ST_FULL;
                        end else begin
                            r_ev_o <= 1'b1;
                            r_ent_o <= wr_data;
                            r_valid[wr_idx] <= 1'b1;
                            r_used[wr_idx] <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // destination keys, written only for a new entry, read beside the entry memory
    always_ff @(posedge i_clk) begin
        if (r_state == S_FINISH && r_type == REQ_UPDATE && accept_upd &&
            !r_found && r_free_ok)
            r_dest[r_free] <= r_da;
        if (rd_en) r_dest_rd <= r_dest[rd_idx];
    end

    assign o_done = r_done;
    assign o_status = r_st_o;
    assign o_found = r_fnd_o;
    assign o_entry_valid = r_ev_o;
    assign o_route_next_hop = r_ent_o.hop;
    assign o_route_metric = r_ent_o.metric;
    assign o_route_seq = r_ent_o.seq;
    assign o_route_lifetime = r_ent_o.lifetime;

    // a result follows only from a busy block or a start
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(o_busy) || $past(i_start)) else $error("stray result");
    // the decision always follows the sweep
    a_sweep_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> $past(r_state) == S_SWEEP) else $error("bad sweep");
    a_full_nf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status == ST_FULL |-> !o_found) else $error("full with found");
endmodule

[tb/sv/aodv_route_table_checker.sv]
`timescale 1ns / 1ps

module aodv_route_table_checker
    import aodv_rt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_now,
    input  logic [31:0] i_dest_addr,
    input  logic [31:0] i_next_hop_addr,
    input  logic [7:0]  i_hop_metric,
    input  logic [31:0] i_seq_number,
    input  logic        i_next_hop_usable,
    input  logic        o_done,
    input  logic [1:0]  o_status,
    input  logic        o_found,
    input  logic        o_entry_valid,
    input  logic [31:0] o_route_next_hop,
    input  logic [7:0]  o_route_metric,
    input  logic [31:0] o_route_seq,
    input  logic [31:0] o_route_lifetime,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        t_status     status;
        logic        found;
        logic        valid;
        logic [31:0] hop;
        logic [7:0]  metric;
        logic [31:0] seq;
        logic [31:0] lifetime;
    } t_route_reply;

    // shadow route table
    logic        used_q     [TableEntries];
    logic        valid_q    [TableEntries];
    logic [31:0] dest_q     [TableEntries];
    logic [31:0] hop_q      [TableEntries];
    logic [7:0]  metric_q   [TableEntries];
    logic [31:0] seq_q      [TableEntries];
    logic [31:0] life_q     [TableEntries];
    logic [31:0] active_timeout;
    logic [31:0] expiry_period;

    t_route_reply pending_replies[$];
    int           fails;

    assign o_fail_count = fails;
    assign o_pending    = pending_replies.size();

    // a lies before b in wrapping time
    function automatic logic is_before(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return d[31];
    endfunction

    function automatic logic is_newer(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic t_route_reply slot_reply(int slot, t_status st, logic hit);
        t_route_reply r;
        r = '0;
        r.status = st;
        r.found  = hit;
        if (slot >= 0) begin
            r.valid    = valid_q[slot];
            r.hop      = hop_q[slot];
            r.metric   = metric_q[slot];
            r.seq      = seq_q[slot];
            r.lifetime = life_q[slot];
        end
        return r;
    endfunction

    // expire, then apply one request to the shadow table
    task automatic route_predict();
        t_route_reply r;
        int           slot;
        logic         hit;
        r    = '0;
        slot = -1;
        if (t_req'(i_req_type) != REQ_NONE) begin
            for (int i = 0; i < TableEntries; i++) begin
                if (used_q[i] && valid_q[i] && is_before(life_q[i], i_now)) begin
                    life_q[i]  = i_now + expiry_period;
                    seq_q[i]   = seq_q[i] + 32'd1;
                    valid_q[i] = 1'b0;
                end
            end
            for (int i = TableEntries - 1; i >= 0; i--)
                if (used_q[i] && dest_q[i] == i_dest_addr) slot = i;
            hit = (slot >= 0);
            case (t_req'(i_req_type))
                REQ_LOOKUP: r = slot_reply(slot, ST_DONE, hit);
                REQ_DELETE: begin
                    r.found = hit;
                    if (hit) begin
                        used_q[slot]  = 1'b0;
                        valid_q[slot] = 1'b0;
                    end
                end
                default: begin
                    if (!i_next_hop_usable) begin
                        r = slot_reply(slot, ST_UNUSABLE, hit);
                    end else if (hit && is_newer(seq_q[slot], i_seq_number)) begin
                        r = slot_reply(slot, ST_STALE, hit);
                    end else if (hit && valid_q[slot] && seq_q[slot] == i_seq_number
                                 && i_hop_metric >= metric_q[slot]) begin
                        r = slot_reply(slot, ST_STALE, hit);
                    end else begin
                        if (!hit) begin
                            for (int i = TableEntries - 1; i >= 0; i--)
                                if (!used_q[i]) slot = i;
                            if (slot >= 0) begin
                                used_q[slot] = 1'b1;
                                dest_q[slot] = i_dest_addr;
                            end
                        end
                        if (slot < 0) begin
                            r.status = ST_FULL;
                        end else begin
                            seq_q[slot]    = i_seq_number;
                            hop_q[slot]    = i_next_hop_addr;
                            metric_q[slot] = i_hop_metric;
                            valid_q[slot]  = 1'b1;
                            life_q[slot]   = i_now + active_timeout;
                            r = slot_reply(slot, ST_DONE, hit);
                        end
                    end
                end
            endcase
        end
        pending_replies.push_back(r);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_route_reply want;
        if (!i_rst_n) begin
            active_timeout = 32'd3000;
            expiry_period  = 32'd15000;
            for (int i = 0; i < TableEntries; i++) begin
                used_q[i]  = 1'b0;
                valid_q[i] = 1'b0;
            end
            pending_replies.delete();
        end else begin
            // compare the result strobe with the oldest prediction
            if (o_done) begin
                if (pending_replies.size() == 0) begin
                    fails++;
                    $display("%0t: result with no request outstanding, status %0d",
                             $time, o_status);
                end else begin
                    want = pending_replies.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("found", want.found, o_found);
                    check_field("entry_valid", want.valid, o_entry_valid);
                    check_field("route_next_hop", want.hop, o_route_next_hop);
                    check_field("route_metric", want.metric, o_route_metric);
                    check_field("route_seq", want.seq, o_route_seq);
                    check_field("route_lifetime", want.lifetime, o_route_lifetime);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == {1'b0, CFG_ACTIVE}) active_timeout = i_cfg_data;
                else if (i_cfg_index == {1'b0, CFG_DELETE}) expiry_period = i_cfg_data;
            end
            if (i_start && !o_busy) route_predict();
        end
    end

    initial fails = 0;

endmodule

[tb/sv/aodv_route_table_unit_tb.sv]
`timescale 1ns / 1ps

module aodv_route_table_unit_tb;
    import aodv_rt_pkg::*;

    localparam int          CycleLimit  = 1_000_000;
    localparam logic [1:0]  CfgSpareLo  = 2'd2;
    localparam logic [1:0]  CfgSpareHi  = 2'd3;
    localparam logic [31:0] PoolBase    = 32'h0A00_0000;
    localparam int          PoolSize    = 72;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_req_type = REQ_LOOKUP;
    logic [31:0] i_now = '0;
    logic [31:0] i_dest_addr = '0;
    logic [31:0] i_next_hop_addr = '0;
    logic [7:0]  i_hop_metric = '0;
    logic [31:0] i_seq_number = '0;
    logic        i_next_hop_usable = 1'b0;
    logic        o_done;
    logic [1:0]  o_status;
    logic        o_found;
    logic        o_entry_valid;
    logic [31:0] o_route_next_hop;
    logic [7:0]  o_route_metric;
    logic [31:0] o_route_seq;
    logic [31:0] o_route_lifetime;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycles = 0;

    logic [31:0] clock_ms = '0;
    logic [31:0] seq_base = '0;
    int          idle_pct = 0;

    aodv_route_table_unit dut (.*);

    aodv_route_table_checker u_checker (
        .*,
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // give up on a hung block
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // hold a request until the block takes it
    task automatic send_req(t_req kind, logic [31:0] now, logic [31:0] dest,
                            logic [31:0] nhop, logic [7:0] metric, logic [31:0] seq,
                            logic usable);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start           <= 1'b1;
        i_req_type        <= kind;
        i_now             <= now;
        i_dest_addr       <= dest;
        i_next_hop_addr   <= nhop;
        i_hop_metric      <= metric;
        i_seq_number      <= seq;
        i_next_hop_usable <= usable;
        do @(posedge i_clk); while (o_busy);
    endtask

    // drain, then write both registers plus the unused indexes
    task automatic set_timers(logic [31:0] active, logic [31:0] expiry);
        logic [1:0]  idx [4];
        logic [31:0] val [4];
        idx = '{{1'b0, CFG_ACTIVE}, {1'b0, CFG_DELETE}, CfgSpareLo, CfgSpareHi};
        val = '{active, expiry, $urandom, $urandom};
        i_start <= 1'b0;
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random();
        t_req        kind;
        logic [31:0] dest;
        logic [31:0] seq;
        logic [7:0]  metric;
        int          pick;
        pick = $urandom_range(0, 99);
        kind = pick < 55 ? REQ_UPDATE : pick < 80 ? REQ_LOOKUP :
               pick < 97 ? REQ_DELETE : REQ_NONE;
        dest = ($urandom_range(0, 99) < 85) ? PoolBase + $urandom_range(0, PoolSize - 1)
                                             : $urandom;
        seq  = ($urandom_range(0, 99) < 95) ? seq_base + $urandom_range(0, 6) : $urandom;
        metric = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 8)) : 8'($urandom);
        clock_ms = ($urandom_range(0, 99) < 2) ? $urandom
                                               : clock_ms + $urandom_range(0, 400);
        if ($urandom_range(0, 99) < 3) seq_base = $urandom;
        send_req(kind, clock_ms, dest, $urandom, metric, seq, $urandom_range(0, 9) != 0);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase one: short timers, light sender gaps
        set_timers(32'd500, 32'd2000);
        idle_pct = 22;
        send_req(REQ_UPDATE, 32'd100, 32'd0, 32'h1, 8'd3, 32'd10, 1'b0);
        send_req(REQ_UPDATE, 32'd100, 32'd0, 32'h1, 8'd3, 32'd10, 1'b1);
        send_req(REQ_LOOKUP, 32'd110, 32'd0, 32'h0, 8'd0, 32'd0, 1'b0);
        send_req(REQ_UPDATE, 32'd120, 32'd0, 32'h2, 8'd3, 32'd10, 1'b1);
        send_req(REQ_UPDATE, 32'd130, 32'd0, 32'h2, 8'd2, 32'd10, 1'b1);
        send_req(REQ_UPDATE, 32'd140, 32'd0, 32'h3, 8'd0, 32'd9, 1'b1);
        send_req(REQ_UPDATE, 32'd150, 32'd0, 32'h3, 8'd9, 32'd11, 1'b1);
        send_req(REQ_UPDATE, 32'd160, 32'd0, 32'h4, 8'd1, 32'h8000_000B, 1'b1);
        send_req(REQ_LOOKUP, 32'd5000, 32'd0, 32'h0, 8'd0, 32'd0, 1'b1);
        send_req(REQ_UPDATE, 32'd5010, 32'd0, 32'h5, 8'd200, 32'd12, 1'b1);
        send_req(REQ_UPDATE, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                 32'hFFFF_FFFF, 1'b1);
        send_req(REQ_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 8'h0, 32'h0, 1'b1);
        send_req(REQ_LOOKUP, 32'h0000_0100, 32'hFFFF_FFFF, 32'h0, 8'h0, 32'h0, 1'b1);
        send_req(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                 32'hFFFF_FFFF, 1'b1);
        send_req(REQ_DELETE, 32'h0000_0200, 32'd0, 32'h0, 8'd0, 32'd0, 1'b1);
        send_req(REQ_DELETE, 32'h0000_0210, 32'd0, 32'h0, 8'd0, 32'd0, 1'b1);
        send_req(REQ_LOOKUP, 32'h0000_0220, 32'd0, 32'h0, 8'd0, 32'd0, 1'b1);
        send_req(REQ_UPDATE, 32'h0000_0230, 32'd0, 32'h0, 8'd0, 32'd0, 1'b0);
        clock_ms = 32'h0000_0300;
        for (int n = 0; n < 250; n++) send_random();

        // phase two: zero timers, heavy sender gaps
        set_timers(32'd0, 32'd0);
        idle_pct = 64;
        for (int n = 0; n < 265; n++) send_random();

        // phase three: largest timers, back to back
        set_timers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        idle_pct = 0;
        for (int n = 0; n < 130; n++) send_random();

        set_timers(32'd3000, 32'd200);
        for (int n = 0; n < 140; n++) send_random();

        i_start <= 1'b0;
        wait (pending == 0);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
